@@ hw/rtl/sbww_pkg.sv @@
package sbww_pkg;

   localparam int COORD_W = 9;
   localparam int COLOR_W = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [COORD_W-1:0] X_START_RESET = 9'd0;
   localparam logic [COORD_W-1:0] X_END_RESET = 9'd319;
   localparam logic [COORD_W-1:0] Y_START_RESET = 9'd0;
   localparam logic [COORD_W-1:0] Y_END_RESET = 9'd479;
   localparam logic [COLOR_W-1:0] COLOR_RESET = 16'h0000;

   localparam logic [7:0] CMD_COLUMN = 8'h2A;
   localparam logic [7:0] CMD_PAGE = 8'h2B;
   localparam logic [7:0] CMD_WRITE = 8'h2C;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_X_START = 3'd0,
      CSR_X_END   = 3'd1,
      CSR_Y_START = 3'd2,
      CSR_Y_END   = 3'd3,
      CSR_COLOR   = 3'd4
   } csr_index_type;

   // one queued job: an optional window sequence and an optional pixel
   typedef struct packed {
      logic               win;
      logic               pix;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
   } job_type;

   typedef enum logic [3:0] {
      STEP_CASET   = 4'd0,
      STEP_COL_HI  = 4'd1,
      STEP_COL_LO  = 4'd2,
      STEP_XEND_HI = 4'd3,
      STEP_XEND_LO = 4'd4,
      STEP_PASET   = 4'd5,
      STEP_ROW_HI  = 4'd6,
      STEP_ROW_LO  = 4'd7,
      STEP_YEND_HI = 4'd8,
      STEP_YEND_LO = 4'd9,
      STEP_RAMWR   = 4'd10,
      STEP_PIX_HI  = 4'd11,
      STEP_PIX_LO  = 4'd12
   } step_type;

endpackage

@@ hw/rtl/sbww_if.sv @@
interface sbww_req_if;
   logic valid;
   logic ready;
   logic pixel_on;
   logic first_bit;

   modport source (output valid, output pixel_on, output first_bit, input ready);
   modport sink (input valid, input pixel_on, input first_bit, output ready);
endinterface

interface sbww_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] bus_byte;
   logic       is_command;
   logic       last_of_run;

   modport source (output valid, output bus_byte, output is_command, output last_of_run,
                   input ready);
   modport sink (input valid, input bus_byte, input is_command, input last_of_run,
                 output ready);
endinterface

@@ hw/rtl/sbww_front.sv @@
module sbww_front
   import sbww_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   sbww_req_if.sink           req_chan,
   input  logic [COORD_W-1:0] x_start,
   input  logic [COORD_W-1:0] x_end,
   input  logic [COORD_W-1:0] y_start,
   input  logic [COORD_W-1:0] y_end,
   input  logic               queue_full,
   output logic               push,
   output job_type            push_job
);

   logic [COORD_W-1:0] scan_x_ff, scan_x_in;
   logic [COORD_W-1:0] scan_y_ff, scan_y_in;
   logic [COORD_W-1:0] window_left_ff, window_left_in;
   logic               gap_seen_ff, gap_seen_in;
   logic               scan_active_ff, scan_active_in;
   logic               accept;
   logic [COORD_W-1:0] cur_x, cur_y, cur_left;
   logic               cur_gap, cur_active;

   assign req_chan.ready = !queue_full;
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      job_type job;
      job = '0;
      if (req_chan.first_bit) begin
         cur_x      = x_start;
         cur_y      = y_start;
         cur_left   = x_start;
         cur_gap    = 1'b0;
         cur_active = (x_start <= x_end) && (y_start <= y_end);
         job.win    = 1'b1;
         job.col    = x_start;
         job.row    = y_start;
      end else begin
         cur_x      = scan_x_ff;
         cur_y      = scan_y_ff;
         cur_left   = window_left_ff;
         cur_gap    = gap_seen_ff;
         cur_active = scan_active_ff;
      end

      scan_x_in      = cur_x;
      scan_y_in      = cur_y;
      window_left_in = cur_left;
      gap_seen_in    = cur_gap;
      scan_active_in = cur_active;

      if (cur_active) begin
         if (req_chan.pixel_on) begin
            // reopen the window at this pixel after a gap or a wrap to the left
            if (cur_gap || (cur_x < cur_left)) begin
               job.win        = 1'b1;
               job.col        = cur_x;
               job.row        = cur_y;
               window_left_in = cur_x;
               gap_seen_in    = 1'b0;
            end
            job.pix = 1'b1;
         end else begin
            gap_seen_in = 1'b1;
         end

         if (cur_x >= x_end) begin
            scan_x_in = x_start;
            if (cur_y >= y_end) begin
               scan_active_in = 1'b0;
            end else begin
               scan_y_in = cur_y + 1'b1;
            end
         end else begin
            scan_x_in = cur_x + 1'b1;
         end
      end
      push_job = job;
   end

   assign push = accept && (push_job.win || push_job.pix);

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_x_ff      <= '0;
         scan_y_ff      <= '0;
         window_left_ff <= '0;
         gap_seen_ff    <= 1'b0;
         scan_active_ff <= 1'b0;
      end else if (accept) begin
         scan_x_ff      <= scan_x_in;
         scan_y_ff      <= scan_y_in;
         window_left_ff <= window_left_in;
         gap_seen_ff    <= gap_seen_in;
         scan_active_ff <= scan_active_in;
      end
   end

   a_first_pushes: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.first_bit) |-> (push && push_job.win))
      else $error("first beat did not queue a window");

endmodule

@@ hw/rtl/sbww_queue.sv @@
module sbww_queue
   import sbww_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type head,
   output logic    empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from empty queue");

endmodule

@@ hw/rtl/sbww_back.sv @@
module sbww_back
   import sbww_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  job_type            head,
   input  logic               empty,
   output logic               pop,
   input  logic [COORD_W-1:0] x_end,
   input  logic [COORD_W-1:0] y_end,
   input  logic [COLOR_W-1:0] pixel_color,
   sbww_rsp_if.source         rsp_chan
);

   logic       started_ff, started_in;
   step_type   step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] byte_ff;
   logic       cmd_ff;
   logic       last_ff;

   step_type   cur_step, end_step;
   logic       load, at_end;
   logic [7:0] sel_byte;
   logic       sel_cmd;

   assign load     = !empty && (!rsp_valid_ff || rsp_chan.ready);
   assign cur_step = started_ff ? step_ff : (head.win ? STEP_CASET : STEP_PIX_HI);
   assign end_step = head.pix ? STEP_PIX_LO : STEP_RAMWR;
   assign at_end   = (cur_step == end_step);
   assign pop      = load && at_end;

   // next step
   always_comb begin
      started_in = started_ff;
      step_in    = step_ff;
      if (load) begin
         if (at_end) begin
            started_in = 1'b0;
         end else begin
            started_in = 1'b1;
            step_in    = step_type'(cur_step + 4'd1);
         end
      end
   end

   // byte of the current step
   always_comb begin
      sel_cmd = 1'b0;
      unique case (cur_step)
         STEP_CASET: begin
            sel_byte = CMD_COLUMN;
            sel_cmd  = 1'b1;
         end
         STEP_COL_HI:  sel_byte = {7'd0, head.col[COORD_W-1]};
         STEP_COL_LO:  sel_byte = head.col[7:0];
         STEP_XEND_HI: sel_byte = {7'd0, x_end[COORD_W-1]};
         STEP_XEND_LO: sel_byte = x_end[7:0];
         STEP_PASET: begin
            sel_byte = CMD_PAGE;
            sel_cmd  = 1'b1;
         end
         STEP_ROW_HI:  sel_byte = {7'd0, head.row[COORD_W-1]};
         STEP_ROW_LO:  sel_byte = head.row[7:0];
         STEP_YEND_HI: sel_byte = {7'd0, y_end[COORD_W-1]};
         STEP_YEND_LO: sel_byte = y_end[7:0];
         STEP_RAMWR: begin
            sel_byte = CMD_WRITE;
            sel_cmd  = 1'b1;
         end
         STEP_PIX_HI:  sel_byte = pixel_color[15:8];
         STEP_PIX_LO:  sel_byte = pixel_color[7:0];
         default:      sel_byte = 8'd0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff   <= 1'b0;
         step_ff      <= STEP_CASET;
         rsp_valid_ff <= 1'b0;
      end else begin
         started_ff   <= started_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= sel_byte;
         cmd_ff  <= sel_cmd;
         last_ff <= at_end;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.bus_byte    = byte_ff;
   assign rsp_chan.is_command  = cmd_ff;
   assign rsp_chan.last_of_run = last_ff;

   a_pop_marks_last: assert property (@(posedge clock) disable iff (reset)
      pop |=> (rsp_valid_ff && last_ff))
      else $error("job retired without a last beat");

endmodule

@@ hw/rtl/sparse_bitmap_window_writer_unit.sv @@
// An accepted item is first written into the job queue; the sequencer behind it then
// registers the first output beat. It sends one output beat per cycle while the receiver
// is ready; a drawn pixel is 2 bytes, a window sequence adds 11, an undrawn pixel adds none.
// Input is taken every cycle while the job queue has room (QUEUE_DEPTH jobs).
// Reset (synchronous, active high) clears scan state, queue and output; registers take
// their power-on values (x_end 319, y_end 479, others 0).
module sparse_bitmap_window_writer_unit
   import sbww_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   sbww_req_if.sink               req_chan,
   sbww_rsp_if.source             rsp_chan,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [COORD_W-1:0] x_start_ff, x_end_ff, y_start_ff, y_end_ff;
   logic [COLOR_W-1:0] color_ff;

   logic    push, pop, full, empty;
   job_type push_job, head;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_start_ff <= X_START_RESET;
         x_end_ff   <= X_END_RESET;
         y_start_ff <= Y_START_RESET;
         y_end_ff   <= Y_END_RESET;
         color_ff   <= COLOR_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_X_START: x_start_ff <= csr_wdata[COORD_W-1:0];
            CSR_X_END:   x_end_ff   <= csr_wdata[COORD_W-1:0];
            CSR_Y_START: y_start_ff <= csr_wdata[COORD_W-1:0];
            CSR_Y_END:   y_end_ff   <= csr_wdata[COORD_W-1:0];
            CSR_COLOR:   color_ff   <= csr_wdata[COLOR_W-1:0];
            default: ;
         endcase
      end
   end

   sbww_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .x_start    (x_start_ff),
      .x_end      (x_end_ff),
      .y_start    (y_start_ff),
      .y_end      (y_end_ff),
      .queue_full (full),
      .push       (push),
      .push_job   (push_job)
   );

   sbww_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (full),
      .pop      (pop),
      .head     (head),
      .empty    (empty)
   );

   sbww_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .empty       (empty),
      .pop         (pop),
      .x_end       (x_end_ff),
      .y_end       (y_end_ff),
      .pixel_color (color_ff),
      .rsp_chan    (rsp_chan)
   );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench
   import sbww_pkg::*;
();

   localparam int SETTLE_CYCLES = 20;
   localparam int LONG_HOLD = 300;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int PHASE_ITEMS = 45;

   typedef struct packed {
      logic [7:0] bus_byte;
      logic       is_command;
      logic       last_of_run;
   } bus_beat_type;

   class bus_byte_predictor;
      logic [COORD_W-1:0] x_start, x_end, y_start, y_end;
      logic [COLOR_W-1:0] colour;
      logic [COORD_W-1:0] scan_x, scan_y, window_left;
      bit                 gap_seen, scan_active;
      bus_beat_type       bytes_due[$];
      int                 mismatches;
      int                 beats_checked;

      function new();
         x_start = X_START_RESET;
         x_end = X_END_RESET;
         y_start = Y_START_RESET;
         y_end = Y_END_RESET;
         colour = COLOR_RESET;
         scan_x = '0;
         scan_y = '0;
         window_left = '0;
         gap_seen = 1'b0;
         scan_active = 1'b0;
         mismatches = 0;
         beats_checked = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_X_START: x_start = value[COORD_W-1:0];
            CSR_X_END:   x_end = value[COORD_W-1:0];
            CSR_Y_START: y_start = value[COORD_W-1:0];
            CSR_Y_END:   y_end = value[COORD_W-1:0];
            CSR_COLOR:   colour = value[COLOR_W-1:0];
            default: ;
         endcase
      endfunction

      function void push_byte(logic [7:0] value, logic cmd);
         bus_beat_type b;
         b.bus_byte = value;
         b.is_command = cmd;
         b.last_of_run = 1'b0;
         bytes_due.push_back(b);
      endfunction

      function void push_word(logic [15:0] value);
         push_byte(value[15:8], 1'b0);
         push_byte(value[7:0], 1'b0);
      endfunction

      function void push_window(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
         push_byte(CMD_COLUMN, 1'b1);
         push_word({7'd0, col});
         push_word({7'd0, x_end});
         push_byte(CMD_PAGE, 1'b1);
         push_word({7'd0, row});
         push_word({7'd0, y_end});
         push_byte(CMD_WRITE, 1'b1);
         window_left = col;
         gap_seen = 1'b0;
      endfunction

      // advance the scan by one mask bit and queue the bytes it causes
      function void take_bit(bit on, bit first);
         int           start;
         bus_beat_type b;
         start = bytes_due.size();
         if (first) begin
            scan_x = x_start;
            scan_y = y_start;
            push_window(x_start, y_start);
            scan_active = (x_start <= x_end) && (y_start <= y_end);
         end
         if (scan_active) begin
            if (on) begin
               if (gap_seen || scan_x < window_left) push_window(scan_x, scan_y);
               push_word(colour);
            end else begin
               gap_seen = 1'b1;
            end
            if (scan_x >= x_end) begin
               scan_x = x_start;
               if (scan_y >= y_end) scan_active = 1'b0;
               else scan_y = scan_y + 1'b1;
            end else begin
               scan_x = scan_x + 1'b1;
            end
         end
         // mark the final byte of this bit, if it caused any
         if (bytes_due.size() > start) begin
            b = bytes_due[bytes_due.size()-1];
            b.last_of_run = 1'b1;
            bytes_due[bytes_due.size()-1] = b;
         end
      endfunction

      function void report(string msg);
         mismatches++;
         if (mismatches <= 10) $display("mismatch: %s", msg);
      endfunction

      function void check_beat(logic [7:0] value, logic cmd, logic last);
         bus_beat_type due;
         beats_checked++;
         if (bytes_due.size() == 0) begin
            report($sformatf("unexpected beat byte %02h cmd %b last %b", value, cmd, last));
         end else begin
            due = bytes_due.pop_front();
            if (due.bus_byte !== value || due.is_command !== cmd || due.last_of_run !== last)
               report($sformatf("expected byte %02h cmd %b last %b, got byte %02h cmd %b last %b",
                                due.bus_byte, due.is_command, due.last_of_run, value, cmd, last));
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   sbww_req_if req_chan ();
   sbww_rsp_if rsp_chan ();

   sparse_bitmap_window_writer_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   bus_byte_predictor predictor = new();

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_cycles = 0;
   int bits_counted = 0;
   int bits_ignored = 0;
   int reg_writes = 0;

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.pixel_on = 1'b0;
      req_chan.first_bit = 1'b0;
      rsp_chan.ready = 1'b0;
   end

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // receiver: a long hold when asked for, random stalls otherwise
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_chan.ready <= 1'b0;
         hold_cycles = hold_cycles - 1;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         predictor.check_beat(rsp_chan.bus_byte, rsp_chan.is_command, rsp_chan.last_of_run);
   end

   initial begin
      int stall_run;
      stall_run = 0;
      while (stall_run < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            stall_run = 0;
         else
            stall_run++;
      end
      $display("timeout after %0d cycles without a beat", WATCHDOG_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   task automatic send_bit(input bit on, input bit first);
      @(negedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_chan.valid <= 1'b1;
      req_chan.pixel_on <= on;
      req_chan.first_bit <= first;
      do @(posedge clock); while (!req_chan.ready);
      if (first || predictor.scan_active) bits_counted++;
      else bits_ignored++;
      predictor.take_bit(on, first);
   endtask

   // drop valid and hold until every queued byte has come out
   task automatic settle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (predictor.bytes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      predictor.set_reg(idx, value);
      reg_writes++;
   endtask

   task automatic configure(input int xs, input int xe, input int ys, input int ye,
                            input logic [COLOR_W-1:0] col);
      settle();
      write_reg(CSR_X_START, CSR_DATA_W'(xs));
      write_reg(CSR_X_END, CSR_DATA_W'(xe));
      write_reg(CSR_Y_START, CSR_DATA_W'(ys));
      write_reg(CSR_Y_END, CSR_DATA_W'(ye));
      write_reg(CSR_COLOR, col);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_segment();
      int                 kind, w, h, xs, xe, ys, ye, len, on_pct;
      bit                 restart, first;
      logic [COLOR_W-1:0] col;
      kind = $urandom_range(9, 0);
      w = $urandom_range(8, 1);
      h = $urandom_range(5, 1);
      if (kind < 7) begin
         xs = $urandom_range(480 - w, 0);
         xe = xs + w - 1;
         ys = $urandom_range(480 - h, 0);
         ye = ys + h - 1;
      end else if (kind == 7) begin
         // empty region, on either axis
         xs = $urandom_range(479, 1);
         ys = $urandom_range(479, 1);
         if ($urandom_range(1, 0)) begin
            xe = $urandom_range(xs - 1, 0);
            ye = $urandom_range(479, ys);
         end else begin
            xe = $urandom_range(479, xs);
            ye = $urandom_range(ys - 1, 0);
         end
      end else begin
         xs = $urandom_range(1, 0) ? 0 : $urandom_range(479, 0);
         xe = $urandom_range(1, 0) ? 479 : $urandom_range(479, xs);
         ys = $urandom_range(1, 0) ? 0 : $urandom_range(479, 0);
         ye = $urandom_range(1, 0) ? 479 : $urandom_range(479, ys);
      end
      case ($urandom_range(3, 0))
         0: col = $urandom_range(1, 0) ? 16'h0000 : 16'hFFFF;
         default: col = COLOR_W'($urandom_range(65535, 0));
      endcase
      configure(xs, xe, ys, ye, col);
      // now and then carry on the old scan under the new registers
      restart = ($urandom_range(4, 0) != 0);
      if (kind == 7) len = 1 + $urandom_range(2, 0);
      else if (kind < 7) len = w * h + $urandom_range(3, 0);
      else len = $urandom_range(40, 10);
      on_pct = $urandom_range(95, 20);
      for (int i = 0; i < len; i++) begin
         first = (i == 0 && restart) || ($urandom_range(99, 0) < 3);
         send_bit($urandom_range(99, 0) < on_pct, first);
      end
   endtask

   initial begin
      int send_pct[4];
      int recv_pct[4];
      int target;
      send_pct = '{0, 81, 0, 34};
      recv_pct = '{0, 0, 81, 34};

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // power-on registers: draw, gap, draw again
      send_bit(1'b1, 1'b1);
      send_bit(1'b0, 1'b0);
      send_bit(1'b1, 1'b0);
      send_bit(1'b1, 1'b0);

      // right and bottom edges; row wrap lands left of the window start
      configure(477, 479, 478, 479, 16'hFFFF);
      send_bit(1'b1, 1'b1);
      send_bit(1'b0, 1'b0);
      send_bit(1'b1, 1'b0);
      send_bit(1'b1, 1'b0);
      send_bit(1'b1, 1'b0);
      send_bit(1'b1, 1'b0);
      send_bit(1'b1, 1'b0);
      send_bit(1'b0, 1'b1);
      send_bit(1'b1, 1'b1);

      // empty regions: window only, following bits dropped
      configure(5, 4, 0, 479, 16'h0000);
      send_bit(1'b1, 1'b1);
      send_bit(1'b1, 1'b0);
      configure(0, 0, 10, 9, 16'h8001);
      send_bit(1'b0, 1'b1);

      // single pixel region
      configure(0, 0, 0, 0, 16'h7FFE);
      send_bit(1'b1, 1'b1);
      send_bit(1'b0, 1'b0);

      // shrink the row while the scan is past the new end
      configure(0, 7, 0, 3, 16'h1234);
      send_bit(1'b1, 1'b1);
      send_bit(1'b1, 1'b0);
      send_bit(1'b1, 1'b0);
      send_bit(1'b0, 1'b0);
      configure(0, 2, 0, 3, 16'h5A5A);
      send_bit(1'b1, 1'b0);
      send_bit(1'b1, 1'b0);

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = send_pct[p];
         recv_stall_pct = recv_pct[p];
         target = bits_counted + PHASE_ITEMS;
         if (p == 0) begin
            // fill the job queue behind a long receiver hold, then pause mid-scan
            configure(0, 479, 0, 479, COLOR_W'($urandom_range(65535, 0)));
            hold_cycles = LONG_HOLD;
            send_bit(1'b1, 1'b1);
            repeat (24) send_bit(1'b1, 1'b0);
            settle();
            repeat (6) send_bit(1'($urandom_range(1, 0)), 1'b0);
         end
         while (bits_counted < target) run_segment();
      end

      settle();
      $display("covered %0d scan bits (%0d dropped outside a scan) over %0d register writes",
               bits_counted, bits_ignored, reg_writes);
      $display("checked %0d bus beats, %0d mismatches, %0d still due",
               predictor.beats_checked, predictor.mismatches, predictor.bytes_due.size());
      if (predictor.mismatches == 0 && predictor.bytes_due.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
